>>> hw/rtl/bmu_pkg.sv
// ----------------------------------------------------------------------------
// bmu_pkg
// Types, command codes and bit helpers shared by the bit manipulation unit.
// ----------------------------------------------------------------------------
package bmu_pkg;

  // command codes
  typedef enum logic [3:0] {
    CMD_ZXT32   = 4'd0,
    CMD_SXT32   = 4'd1,
    CMD_POPCNT  = 4'd2,
    CMD_REV32   = 4'd3,
    CMD_MSB_IDX = 4'd4,
    CMD_LSB_IDX = 4'd5,
    CMD_KEEP_HI = 4'd6,
    CMD_KEEP_LO = 4'd7,
    CMD_ZXT64   = 4'd8,
    CMD_SXT64   = 4'd9
  } cmd_t;

  localparam logic [31:0] M1     = 32'h5555_5555;
  localparam logic [31:0] M2     = 32'h3333_3333;
  localparam logic [31:0] M4     = 32'h0F0F_0F0F;
  localparam logic [31:0] M8     = 32'h00FF_00FF;
  localparam logic [31:0] LOW32  = 32'hFFFF_FFFF;

  // input transaction
  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] value;
    logic [5:0]  field_offset;
    logic [6:0]  field_count;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [63:0] result;
    logic        bad_field;
  } out_item_t;

  // population count of a 32-bit word, tree of partial sums
  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & M1);
    b = (a & M2) + ((a >> 2) & M2);
    c = (b + (b >> 4)) & M4;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

  // full 32-bit bit reversal
  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31 - i];
    end
    return r;
  endfunction

  // set every bit below the highest set bit
  function automatic logic [31:0] smear32(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

endpackage

>>> hw/rtl/bit_manipulation_unit.sv
// ----------------------------------------------------------------------------
// bit_manipulation_unit
// Opcode-selected bit manipulation: field extract, popcount, reverse, scans.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command transaction (cmd, value, field_offset,
//   field_count); out_valid/out_ready carry one result transaction (result,
//   bad_field) per command, in order.
//   The block is a two-register pipeline: the command is captured in an
//   input register, the operation is evaluated combinationally, and the
//   answer is captured in the result register, which raises out_valid. A stall
//   can hold a command in either register; throughput is one transaction per
//   cycle while out_ready stays high.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; in_ready then drops until out_ready returns.
//   in_ready is driven combinationally from out_ready.
//   Synchronous reset (rst_n low) empties both registers; no transaction is
//   presented until a new command is accepted.
//   Illegal extract fields (count zero or offset+count above the width)
//   give result zero with bad_field set. Unused command codes give zero.
// ----------------------------------------------------------------------------
module bit_manipulation_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmu_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmu_pkg::out_item_t  out_data
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  bmu_pkg::in_item_t  s1_data_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  bmu_pkg::out_item_t out_data_r;
  bmu_pkg::out_item_t calc;
  logic               out_free;
  logic               s1_adv;
  logic               in_acc;

  // handshake control
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= calc;
    end
  end

  // extract datapath
  logic [31:0] lo;
  logic [7:0]  fsum;
  logic [5:0]  ftop;
  logic [63:0] fmask;
  logic [63:0] fbits;
  logic [63:0] fext;
  logic        fsign;
  logic        bad32;
  logic        bad64;
  logic [31:0] lo_low;
  logic [31:0] lo_smear;

  always_comb begin
    lo       = s1_data_r.value[31:0];
    fsum     = {2'b00, s1_data_r.field_offset} + {1'b0, s1_data_r.field_count};
    ftop     = 6'(fsum - 8'd1);
    fmask    = ~({64{1'b1}} << s1_data_r.field_count);
    fbits    = (s1_data_r.value >> s1_data_r.field_offset) & fmask;
    fsign    = s1_data_r.value[ftop];
    bad32    = (s1_data_r.field_count == 7'd0) || (fsum > 8'd32);
    bad64    = (s1_data_r.field_count == 7'd0) || (fsum > 8'd64);
    lo_low   = lo & (32'd0 - lo);
    lo_smear = bmu_pkg::smear32(lo);
  end

  // operation select
  always_comb begin
    calc.result    = '0;
    calc.bad_field = 1'b0;
    fext           = fbits;
    unique case (s1_data_r.cmd)
      bmu_pkg::CMD_ZXT32, bmu_pkg::CMD_SXT32: begin
        if (bad32) begin
          calc.bad_field = 1'b1;
        end else begin
          if ((s1_data_r.cmd == bmu_pkg::CMD_SXT32) && fsign) begin
            fext = fbits | ~fmask;
          end
          calc.result = {32'd0, fext[31:0]};
        end
      end
      bmu_pkg::CMD_ZXT64, bmu_pkg::CMD_SXT64: begin
        if (bad64) begin
          calc.bad_field = 1'b1;
        end else begin
          if ((s1_data_r.cmd == bmu_pkg::CMD_SXT64) && fsign) begin
            fext = fbits | ~fmask;
          end
          calc.result = fext;
        end
      end
      bmu_pkg::CMD_POPCNT: begin
        calc.result = {58'd0, bmu_pkg::pop32(lo)};
      end
      bmu_pkg::CMD_REV32: begin
        calc.result = {32'd0, bmu_pkg::rev32(lo)};
      end
      bmu_pkg::CMD_MSB_IDX: begin
        if (lo == 32'd0) begin
          calc.result = {32'd0, bmu_pkg::LOW32};
        end else begin
          calc.result = {58'd0, 6'(bmu_pkg::pop32(lo_smear) - 6'd1)};
        end
      end
      bmu_pkg::CMD_LSB_IDX: begin
        if (lo == 32'd0) begin
          calc.result = {32'd0, bmu_pkg::LOW32};
        end else begin
          calc.result = {58'd0, bmu_pkg::pop32(lo_low - 32'd1)};
        end
      end
      bmu_pkg::CMD_KEEP_HI: begin
        calc.result = {32'd0, lo_smear - (lo_smear >> 1)};
      end
      bmu_pkg::CMD_KEEP_LO: begin
        calc.result = {32'd0, lo_low};
      end
      default: begin
        calc.result    = '0;
        calc.bad_field = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted command not held in input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |-> !in_ready)
    else $error("input register overwritten while blocked");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.bad_field) |-> (out_data_r.result == 64'd0))
    else $error("illegal field result not zero");

  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("evaluated command lost");

endmodule

>>> tb/bit_manipulation_unit_checker.sv
// ----------------------------------------------------------------------------
// bit_manipulation_unit_checker
// Watches both channels of the bit manipulation unit. Each accepted command
// is evaluated by an independent model into an expected result. Each
// accepted result is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module bit_manipulation_unit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bmu_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bmu_pkg::out_item_t  out_data,
  output int                  mismatch_count,
  output int                  results_outstanding,
  output int                  results_checked,
  output int                  bad_fields_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  bmu_pkg::out_item_t awaited_results[$];

  // expected answer of one command
  function automatic bmu_pkg::out_item_t bitop_result(input bmu_pkg::in_item_t cmd_item);
    bmu_pkg::out_item_t r;
    logic [31:0] lo;
    logic [31:0] rv;
    logic [63:0] mask;
    logic [63:0] fld;
    int          ofs;
    int          cnt;
    int          width;
    int          hi_idx;
    int          lo_idx;
    bit          is_signed;
    r      = '0;
    lo     = cmd_item.value[31:0];
    ofs    = int'(cmd_item.field_offset);
    cnt    = int'(cmd_item.field_count);
    hi_idx = -1;
    lo_idx = -1;
    for (int i = 0; i < 32; i++) begin
      if (lo[i]) hi_idx = i;
    end
    for (int i = 31; i >= 0; i--) begin
      if (lo[i]) lo_idx = i;
    end
    case (cmd_item.cmd)
      bmu_pkg::CMD_ZXT32, bmu_pkg::CMD_SXT32, bmu_pkg::CMD_ZXT64, bmu_pkg::CMD_SXT64: begin
        width     = (cmd_item.cmd == bmu_pkg::CMD_ZXT64 ||
                     cmd_item.cmd == bmu_pkg::CMD_SXT64) ? 64 : 32;
        is_signed = (cmd_item.cmd == bmu_pkg::CMD_SXT32 ||
                     cmd_item.cmd == bmu_pkg::CMD_SXT64);
        // illegal field gives zero with the flag
        if (cnt == 0 || ofs + cnt > width) begin
          r.bad_field = 1'b1;
        end else begin
          mask = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1);
          fld  = (cmd_item.value >> ofs) & mask;
          if (is_signed && fld[cnt-1]) fld = fld | ~mask;
          if (width == 32) fld[63:32] = '0;
          r.result = fld;
        end
      end
      bmu_pkg::CMD_POPCNT: begin
        r.result = 64'($countones(lo));
      end
      bmu_pkg::CMD_REV32: begin
        rv       = {<<{lo}};
        r.result = {32'd0, rv};
      end
      // bit scans of zero answer with all-ones in the low word
      bmu_pkg::CMD_MSB_IDX: begin
        r.result = (lo == '0) ? {32'd0, bmu_pkg::LOW32} : 64'(hi_idx);
      end
      bmu_pkg::CMD_LSB_IDX: begin
        r.result = (lo == '0) ? {32'd0, bmu_pkg::LOW32} : 64'(lo_idx);
      end
      bmu_pkg::CMD_KEEP_HI: begin
        r.result = (lo == '0) ? 64'd0 : (64'd1 << hi_idx);
      end
      bmu_pkg::CMD_KEEP_LO: begin
        r.result = (lo == '0) ? 64'd0 : (64'd1 << lo_idx);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // compare result transactions, then record newly accepted commands
  always @(posedge clk) begin
    bmu_pkg::out_item_t exp_item;
    if (!rst_n) begin
      mismatch_count      = 0;
      results_outstanding = 0;
      results_checked     = 0;
      bad_fields_seen     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction: result=%h bad_field=%b",
                   $realtime, out_data.result, out_data.bad_field);
        end else begin
          exp_item = awaited_results.pop_front();
          results_checked++;
          if (exp_item.bad_field) bad_fields_seen++;
          if (out_data.result !== exp_item.result) begin
            mismatch_count++;
            $display("%0t: result mismatch: expected %h, actual %h",
                     $realtime, exp_item.result, out_data.result);
          end
          if (out_data.bad_field !== exp_item.bad_field) begin
            mismatch_count++;
            $display("%0t: bad_field mismatch: expected %b, actual %b",
                     $realtime, exp_item.bad_field, out_data.bad_field);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(bitop_result(in_data));
      end
      results_outstanding = awaited_results.size();
    end
  end

endmodule

>>> tb/bit_manipulation_unit_tb.sv
// ----------------------------------------------------------------------------
// bit_manipulation_unit_tb
// Drives directed corner commands and then randomized commands through the
// bit manipulation unit with random idling on both channels and one long
// receiver stall; the checker module does all result comparison.
// ----------------------------------------------------------------------------
module bit_manipulation_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          HOLD_CYCLES   = 60;
  localparam logic [3:0]  CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  bmu_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bmu_pkg::out_item_t out_data;

  int        mismatch_count;
  int        results_outstanding;
  int        results_checked;
  int        bad_fields_seen;
  bit        calm      = 1'b0;
  bit        hold_req  = 1'b0;
  bit        hold_done = 1'b0;

  // 10 ns clock
  always #5 clk = ~clk;

  bit_manipulation_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bit_manipulation_unit_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding),
    .results_checked     (results_checked),
    .bad_fields_seen     (bad_fields_seen)
  );

  function automatic bmu_pkg::in_item_t make_cmd(input logic [3:0] cmd,
                                                 input logic [63:0] value,
                                                 input int ofs, input int cnt);
    bmu_pkg::in_item_t it;
    it.cmd          = cmd;
    it.value        = value;
    it.field_offset = 6'(ofs);
    it.field_count  = 7'(cnt);
    return it;
  endfunction

  // operand patterns: dense, empty, full, single bit, sparse
  function automatic logic [63:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly legal fields for the chosen width, some arbitrary ones
  function automatic bmu_pkg::in_item_t random_cmd();
    logic [3:0] cmd;
    int         width;
    int         cnt;
    int         ofs;
    if ($urandom_range(0, 99) < 4) cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else cmd = 4'($urandom_range(bmu_pkg::CMD_ZXT32, bmu_pkg::CMD_SXT64));
    width = (cmd == bmu_pkg::CMD_ZXT64 || cmd == bmu_pkg::CMD_SXT64) ? 64 : 32;
    if ($urandom_range(0, 99) < 15) begin
      ofs = $urandom_range(0, 63);
      cnt = $urandom_range(0, 127);
    end else begin
      cnt = $urandom_range(1, width);
      ofs = $urandom_range(0, width - cnt);
    end
    return make_cmd(cmd, random_operand(), ofs, cnt);
  endfunction

  // offer one transaction, called and returning at a falling edge
  task automatic offer(input bmu_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // run time limit
  initial begin
    #1_000_000;
    $display("bit_manipulation_unit test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    offer(make_cmd(bmu_pkg::CMD_ZXT32, '1, 0, 32));
    offer(make_cmd(bmu_pkg::CMD_SXT32, 64'hFFFF_FFFF_0000_0F00, 8, 4));
    offer(make_cmd(bmu_pkg::CMD_SXT32, 64'h0000_0000_8000_0000, 31, 1));
    offer(make_cmd(bmu_pkg::CMD_ZXT32, 64'h1234_5678_9ABC_DEF0, 4, 0));
    offer(make_cmd(bmu_pkg::CMD_SXT32, '1, 31, 2));
    offer(make_cmd(bmu_pkg::CMD_ZXT64, 64'h8123_4567_89AB_CDEF, 0, 64));
    offer(make_cmd(bmu_pkg::CMD_SXT64, 64'h8000_0000_0000_0000, 63, 1));
    offer(make_cmd(bmu_pkg::CMD_SXT64, 64'h8123_4567_89AB_CDEF, 0, 64));
    offer(make_cmd(bmu_pkg::CMD_ZXT64, '1, 60, 5));
    offer(make_cmd(bmu_pkg::CMD_SXT64, '1, 63, 127));
    offer(make_cmd(bmu_pkg::CMD_ZXT64, 64'hF000_0000_0000_0000, 32, 32));
    offer(make_cmd(bmu_pkg::CMD_POPCNT, '1, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_POPCNT, 64'hFFFF_FFFF_0000_0000, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_REV32, 64'hFFFF_FFFF_0000_0001, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_MSB_IDX, 64'hFFFF_FFFF_0000_0000, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_MSB_IDX, 64'h0000_0000_8000_0000, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_LSB_IDX, 64'd0, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_LSB_IDX, 64'h0000_0000_8000_0000, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_KEEP_HI, 64'hFFFF_FFFF_0000_0000, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_KEEP_HI, '1, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_KEEP_LO, 64'd0, 0, 0));
    offer(make_cmd(bmu_pkg::CMD_KEEP_LO, 64'h0000_0000_8000_0000, 0, 0));
    offer(make_cmd(CMD_UNUSED_LO, '1, 63, 127));
    offer(make_cmd(CMD_UNUSED_HI, '1, 0, 1));

    // random commands, with a quiet stretch and a long receiver stall
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 700) calm = 1'b1;
      if (n == 900) calm = 1'b0;
      offer(random_cmd());
    end
    in_valid <= 1'b0;

    // drain
    while (results_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("covered %0d commands over all opcodes, %0d with an illegal field,",
             results_checked, bad_fields_seen);
    $display("with random idling, a quiet stretch and a %0d-cycle receiver stall",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("bit_manipulation_unit test passed");
    end else begin
      $display("bit_manipulation_unit test failed");
    end
    $finish;
  end

endmodule

>>> bit_manipulation_unit.f
hw/rtl/bmu_pkg.sv
hw/rtl/bit_manipulation_unit.sv
tb/bit_manipulation_unit_checker.sv
tb/bit_manipulation_unit_tb.sv
